/* rtl/core/mf3_pkg.sv */
// Shared types and constants of the 3x3 median filter.
// No dependencies; the line store, the median pipeline and the top level import it.
package mf3_pkg;

  typedef logic [7:0] pix_t;

  // Configuration register indexes and reset values.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned CFG_WIDTH_BITS  = 11;
  localparam int unsigned CFG_HEIGHT_BITS = 13;
  localparam int unsigned CFG_DATA_BITS   = 13;

  localparam logic [CFG_WIDTH_BITS-1:0]  IMAGE_WIDTH_RESET  = 11'd512;
  localparam logic [CFG_HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd512;

  // Smallest frame dimension in use.
  localparam int unsigned MIN_DIM = 3;

  typedef struct packed {
    pix_t pixel;
  } pix_item_t;

  typedef struct packed {
    pix_t        median;
    logic [9:0]  center_column;
    logic [11:0] center_row;
    logic        frame_last;
  } res_item_t;

  // Per-pixel control that travels with a pixel from the line store stage
  // into the median pipeline.
  typedef struct packed {
    logic        emit;
    logic [9:0]  center_column;
    logic [11:0] center_row;
    logic        frame_last;
  } meta_t;

endpackage

/* rtl/core/mf3_stream_if.sv */
// Valid/ready stream interface used for the pixel and result channels.
// Depends on nothing; the payload type is set where the interface is instantiated.
interface mf3_stream_if #(
  parameter type item_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mf3_line_store.sv */
// Line store memory: previous two image rows packed side by side per column.
// Synchronous write, registered read; uses mf3_pkg for the pixel type.
module mf3_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  mf3_pkg::pix_t     wupper_i,
  input  mf3_pkg::pix_t     wmiddle_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output mf3_pkg::pix_t     rupper_o,
  output mf3_pkg::pix_t     rmiddle_o
);
  import mf3_pkg::*;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wupper_i, wmiddle_i};
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rupper_o  = rdata_q[15:8];
  assign rmiddle_o = rdata_q[7:0];

endmodule

/* rtl/core/mf3_median.sv */
// Window of sorted columns and the median pipeline with its output register.
// Uses mf3_pkg types and drives the result channel (mf3_stream_if).
module mf3_median (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  mf3_pkg::pix_t      upper_i,
  input  mf3_pkg::pix_t      middle_i,
  input  mf3_pkg::pix_t      lower_i,
  input  mf3_pkg::meta_t     meta_i,
  output logic               ready_o,
  mf3_stream_if.source       res_o
);
  import mf3_pkg::*;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // The window keeps each column already sorted into low, middle and high.
  // The median of nine is then the median of the largest low, the middle
  // of the middles and the smallest high.
  pix_t win_lo_q [3];
  pix_t win_md_q [3];
  pix_t win_hi_q [3];

  pix_t new_lo, new_md, new_hi;

  logic   b_v_q;
  meta_t  b_meta_q;
  logic   c_v_q;
  meta_t  c_meta_q;
  pix_t   c_lo_q, c_md_q, c_hi_q;
  logic   d_v_q;
  res_item_t d_res_q;

  logic b_ready, c_ready, d_ready;

  assign d_ready = !d_v_q || res_o.ready;
  assign c_ready = !c_v_q || d_ready;
  assign b_ready = !b_v_q || c_ready;
  assign ready_o = b_ready;

  always_comb begin
    new_lo = min2(min2(upper_i, middle_i), lower_i);
    new_hi = max2(max2(upper_i, middle_i), lower_i);
    new_md = med3(upper_i, middle_i, lower_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_lo_q[i] <= '0;
        win_md_q[i] <= '0;
        win_hi_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_lo_q[0] <= win_lo_q[1];
      win_lo_q[1] <= win_lo_q[2];
      win_lo_q[2] <= new_lo;
      win_md_q[0] <= win_md_q[1];
      win_md_q[1] <= win_md_q[2];
      win_md_q[2] <= new_md;
      win_hi_q[0] <= win_hi_q[1];
      win_hi_q[1] <= win_hi_q[2];
      win_hi_q[2] <= new_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (b_ready) begin
        b_v_q <= shift_i && meta_i.emit;
      end
      if (c_ready) begin
        c_v_q <= b_v_q;
      end
      if (d_ready) begin
        d_v_q <= c_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_meta_q <= meta_i;
    end
    if (c_ready) begin
      c_meta_q <= b_meta_q;
      c_lo_q   <= max2(max2(win_lo_q[0], win_lo_q[1]), win_lo_q[2]);
      c_md_q   <= med3(win_md_q[0], win_md_q[1], win_md_q[2]);
      c_hi_q   <= min2(min2(win_hi_q[0], win_hi_q[1]), win_hi_q[2]);
    end
    if (d_ready) begin
      d_res_q.median        <= med3(c_lo_q, c_md_q, c_hi_q);
      d_res_q.center_column <= c_meta_q.center_column;
      d_res_q.center_row    <= c_meta_q.center_row;
      d_res_q.frame_last    <= c_meta_q.frame_last;
    end
  end

  assign res_o.valid = d_v_q;
  assign res_o.data  = d_res_q;

endmodule

/* rtl/core/median_filter_3x3_unit.sv */
// Streaming 3x3 median filter, top level: configuration, raster counters and
// the line store stage. Uses mf3_pkg, mf3_stream_if, mf3_line_store, mf3_median.
//
// Pixels of an 8-bit grayscale frame enter in raster order at one per clock
// unless results stall; the rate is set by the single line store memory, which
// takes one read and one write for every pixel. The pixel that completes a 3x3
// window passes registers A, B and C; a result leaves register D only for
// interior pixels; border pixels give no result and are left for the consumer
// to fill with zero. Each result carries the median, the centre coordinates and
// a flag on the frame's last interior pixel. The pipeline keeps accepting while
// a result waits, until every stage holds a request. Width and height are
// clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT and should be written only while the
// block is idle. The line store has no reset and needs no clearing pass.
module median_filter_3x3_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  mf3_stream_if.sink                      pix_i,
  mf3_stream_if.source                    res_o
);
  import mf3_pkg::*;

  localparam int unsigned WB = $clog2(MAX_WIDTH);
  localparam int unsigned HB = $clog2(MAX_HEIGHT);

  logic [CFG_WIDTH_BITS-1:0]  image_width_q;
  logic [CFG_HEIGHT_BITS-1:0] image_height_q;

  logic [WB:0] w_use;
  logic [HB:0] h_use;

  logic [WB-1:0] col_q, col_d;
  logic [HB-1:0] row_q, row_d;

  logic   a_v_q;
  pix_t   a_px_q;
  logic [WB-1:0] a_col_q;
  meta_t  a_meta_q;
  meta_t  meta_d;

  logic   a_ready, b_ready, accept, a_adv;
  pix_t   rd_upper, rd_middle;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RESET;
      image_height_q <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[CFG_WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[CFG_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width_q) < MIN_DIM) begin
      w_use = (WB+1)'(MIN_DIM);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_use = (WB+1)'(MAX_WIDTH);
    end else begin
      w_use = (WB+1)'(image_width_q);
    end
    if (32'(image_height_q) < MIN_DIM) begin
      h_use = (HB+1)'(MIN_DIM);
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_use = (HB+1)'(MAX_HEIGHT);
    end else begin
      h_use = (HB+1)'(image_height_q);
    end
  end

  assign a_ready     = !a_v_q || b_ready;
  assign pix_i.ready = a_ready;
  assign accept      = pix_i.valid && a_ready;
  assign a_adv       = a_v_q && b_ready;

  // Position of the next pixel and what its result, if any, will carry.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if ({1'b0, col_q} >= w_use - 1'b1) begin
      col_d = '0;
      if ({1'b0, row_q} >= h_use - 1'b1) begin
        row_d = '0;
      end else begin
        row_d = row_q + 1'b1;
      end
    end else begin
      col_d = col_q + 1'b1;
    end

    meta_d.emit = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2) &&
                  ({1'b0, row_q} < h_use) && ({1'b0, col_q} < w_use);
    meta_d.center_column = 10'(col_q - WB'(1));
    meta_d.center_row    = 12'(row_q - HB'(1));
    meta_d.frame_last    = ({1'b0, row_q} == h_use - 1'b1) &&
                           ({1'b0, col_q} == w_use - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      a_v_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (a_ready) begin
        a_v_q <= pix_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_px_q   <= pix_i.data.pixel;
      a_col_q  <= col_q;
      a_meta_q <= meta_d;
    end
  end

  // The column is read when the pixel is accepted and written back when it
  // leaves this stage. Consecutive pixels never share a column, so the read
  // of the next pixel never meets the pending write.
  mf3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (WB)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (a_adv),
    .waddr_i   (a_col_q),
    .wupper_i  (rd_middle),
    .wmiddle_i (a_px_q),
    .re_i      (accept),
    .raddr_i   (col_q),
    .rupper_o  (rd_upper),
    .rmiddle_o (rd_middle)
  );

  mf3_median u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (a_adv),
    .upper_i  (rd_upper),
    .middle_i (rd_middle),
    .lower_i  (a_px_q),
    .meta_i   (a_meta_q),
    .ready_o  (b_ready),
    .res_o    (res_o)
  );

endmodule
